@@ src/rgb_to_hsv_converter_core_defines.svh @@
// Assertion macros shared by the checker of the RGB to HSV converter.
`ifndef RGB_TO_HSV_CONVERTER_CORE_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define R2H_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define R2H_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/r2h_pkg.sv @@
// Shared types, constants and the divider step function of the RGB to HSV converter.
package r2h_pkg;

  // Channel and result widths.
  localparam int unsigned ChanW   = 8;
  localparam int unsigned HueW    = 15;
  localparam int unsigned QuotW   = 12;
  localparam int unsigned NumW    = ChanW + QuotW;
  localparam int unsigned DivSteps = QuotW;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 32;

  // Hue constants in degrees times 64.
  localparam logic [HueW-1:0] HueSixth     = 15'd3840;
  localparam logic [HueW-1:0] HueGreenBase = 15'd7680;
  localparam logic [HueW-1:0] HueGreyVal   = 15'd11520;
  localparam logic [HueW-1:0] HueBlueBase  = 15'd15360;
  localparam logic [HueW-1:0] HueFull      = 15'd23040;

  // Which channel holds the maximum.
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } r2h_sector_e;

  // Values after the min/max stage.
  typedef struct packed {
    logic [ChanW-1:0] brightness;
    logic [ChanW-1:0] delta;
    logic [ChanW-1:0] mag;
    logic             neg;
    r2h_sector_e      sector;
  } r2h_pre_t;

  // One divider lane: partial remainder, numerator bits shifting out at the
  // top while quotient bits shift in at the bottom, and the divisor.
  typedef struct packed {
    logic [ChanW-1:0] rem;
    logic [QuotW-1:0] bits;
    logic [ChanW-1:0] den;
  } r2h_lane_t;

  // Item traveling through the divider pipeline.
  typedef struct packed {
    r2h_lane_t        hue_lane;
    r2h_lane_t        sat_lane;
    logic [ChanW-1:0] brightness;
    logic             neg;
    logic             black;
    logic             grey;
    r2h_sector_e      sector;
  } r2h_item_t;

  // One restoring division step: brings in the next numerator bit and
  // produces one quotient bit. The remainder stays below the divisor.
  function automatic r2h_lane_t div_step(input r2h_lane_t lane);
    r2h_lane_t      res;
    logic [ChanW:0] trial;
    logic [ChanW:0] diff;
    res   = lane;
    trial = {lane.rem, lane.bits[QuotW-1]};
    diff  = trial - {1'b0, lane.den};
    if (trial >= {1'b0, lane.den}) begin
      res.rem  = diff[ChanW-1:0];
      res.bits = {lane.bits[QuotW-2:0], 1'b1};
    end else begin
      res.rem  = trial[ChanW-1:0];
      res.bits = {lane.bits[QuotW-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

@@ src/r2h_front.sv @@
// Front stages: channel min/max and sector, then divider numerators.
module r2h_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  logic [r2h_pkg::ChanW-1:0] red_i,
  input  logic [r2h_pkg::ChanW-1:0] green_i,
  input  logic [r2h_pkg::ChanW-1:0] blue_i,
  output logic                      valid_o,
  output r2h_pkg::r2h_item_t        item_o
);
  import r2h_pkg::*;

  logic                  pre_valid_q;
  r2h_pre_t              pre_d, pre_q;
  logic                  item_valid_q;
  r2h_item_t             item_d, item_q;
  logic [ChanW-1:0]      mx, mn;
  logic [ChanW:0]        diff;
  logic [NumW-1:0]       hue_num, sat_num;

  // Maximum, minimum and sector; red wins ties, then green.
  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    pre_d.brightness = mx;
    pre_d.delta      = mx - mn;
    if (red_i >= green_i && red_i >= blue_i) begin
      pre_d.sector = SEC_RED;
      diff = {1'b0, green_i} - {1'b0, blue_i};
    end else if (green_i >= blue_i) begin
      pre_d.sector = SEC_GREEN;
      diff = {1'b0, blue_i} - {1'b0, red_i};
    end else begin
      pre_d.sector = SEC_BLUE;
      diff = {1'b0, red_i} - {1'b0, green_i};
    end
    pre_d.neg = diff[ChanW];
    pre_d.mag = diff[ChanW] ? ChanW'(-diff) : diff[ChanW-1:0];
  end

  // Numerators: 3840 * mag for hue and 255 * delta for saturation.
  always_comb begin
    hue_num = {pre_q.mag, 12'b0} - {4'b0, pre_q.mag, 8'b0};
    sat_num = {4'b0, pre_q.delta, 8'b0} - {12'b0, pre_q.delta};
    item_d.hue_lane.rem  = hue_num[NumW-1:QuotW];
    item_d.hue_lane.bits = hue_num[QuotW-1:0];
    item_d.hue_lane.den  = pre_q.delta;
    item_d.sat_lane.rem  = sat_num[NumW-1:QuotW];
    item_d.sat_lane.bits = sat_num[QuotW-1:0];
    item_d.sat_lane.den  = pre_q.brightness;
    item_d.brightness    = pre_q.brightness;
    item_d.neg           = pre_q.neg;
    item_d.black         = (pre_q.brightness == '0);
    item_d.grey          = (pre_q.delta == '0);
    item_d.sector        = pre_q.sector;
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_valid_q  <= 1'b0;
      item_valid_q <= 1'b0;
    end else if (adv_i) begin
      pre_valid_q  <= valid_i;
      item_valid_q <= pre_valid_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pre_q  <= pre_d;
      item_q <= item_d;
    end
  end

  assign valid_o = item_valid_q;
  assign item_o  = item_q;

endmodule

@@ src/r2h_div_step.sv @@
// One registered quotient-bit stage for both the hue and saturation dividers.
module r2h_div_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  r2h_pkg::r2h_item_t item_i,
  output logic               valid_o,
  output r2h_pkg::r2h_item_t item_o
);
  import r2h_pkg::*;

  logic      valid_q;
  r2h_item_t item_d, item_q;

  // Both lanes advance by one quotient bit.
  always_comb begin
    item_d          = item_i;
    item_d.hue_lane = div_step(item_i.hue_lane);
    item_d.sat_lane = div_step(item_i.sat_lane);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ src/r2h_back.sv @@
// Final stage: signed hue offset, sector base, wrap and the output register.
module r2h_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  r2h_pkg::r2h_item_t        item_i,
  output logic                      valid_o,
  output logic [r2h_pkg::HueW-1:0]  hue_o,
  output logic [r2h_pkg::ChanW-1:0] saturation_o,
  output logic [r2h_pkg::ChanW-1:0] brightness_o
);
  import r2h_pkg::*;

  logic             valid_q;
  logic [HueW-1:0]  hue_d, hue_q;
  logic [ChanW-1:0] sat_d, sat_q;
  logic [ChanW-1:0] bright_q;
  logic [HueW-1:0]  quot;

  // Hue from the sector base and the signed quotient; a negative red hue wraps.
  always_comb begin
    quot = {{(HueW-QuotW){1'b0}}, item_i.hue_lane.bits};
    case (item_i.sector)
      SEC_RED: begin
        hue_d = (item_i.neg && quot != '0) ? HueFull - quot : quot;
      end
      SEC_GREEN: begin
        hue_d = item_i.neg ? HueGreenBase - quot : HueGreenBase + quot;
      end
      SEC_BLUE: begin
        hue_d = item_i.neg ? HueBlueBase - quot : HueBlueBase + quot;
      end
      default: begin
        hue_d = HueGreyVal;
      end
    endcase
    if (item_i.grey) hue_d = HueGreyVal;
    sat_d = item_i.black ? '0 : item_i.sat_lane.bits[ChanW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      hue_q    <= hue_d;
      sat_q    <= sat_d;
      bright_q <= item_i.brightness;
    end
  end

  assign valid_o      = valid_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bright_q;

endmodule

@@ src/rgb_to_hsv_converter_core.sv @@
// Top level of the pipelined RGB to HSV pixel converter.
//
// Channel   Direction  Beat contents (lowest bit first)
// s_axis    in         red[7:0], green[15:8], blue[23:16]
// m_axis    out        hue[14:0], saturation[22:15], brightness[30:23], zero[31]
//
// One pixel enters per clock while s_axis_tready_o is high; each result passes
// through two front stages, twelve divider stages (one quotient bit each for
// the hue and saturation dividers), and the output register.
// Reset clears only the valid bits; payload registers are not reset.
// The whole pipeline holds while a result waits on m_axis, so nothing is lost
// or repeated; s_axis_tready_o is high whenever the output register is empty
// or being taken.
module rgb_to_hsv_converter_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // red[7:0], green[15:8], blue[23:16]
  input  logic [r2h_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // hue[14:0], saturation[22:15], brightness[30:23], zero pad[31]
  output logic [r2h_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import r2h_pkg::*;

  logic             adv;
  logic             stage_valid [DivSteps+1];
  r2h_item_t        stage_item  [DivSteps+1];
  logic             out_valid;
  logic [HueW-1:0]  hue;
  logic [ChanW-1:0] saturation;
  logic [ChanW-1:0] brightness;

  // Global advance: move when the output register is empty or being taken.
  assign adv             = !out_valid || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  r2h_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s_axis_tvalid_i),
    .red_i   (s_axis_tdata_i[7:0]),
    .green_i (s_axis_tdata_i[15:8]),
    .blue_i  (s_axis_tdata_i[23:16]),
    .valid_o (stage_valid[0]),
    .item_o  (stage_item[0])
  );

  // Divider chain, one quotient bit per stage.
  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    r2h_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (stage_valid[i]),
      .item_i  (stage_item[i]),
      .valid_o (stage_valid[i+1]),
      .item_o  (stage_item[i+1])
    );
  end

  r2h_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .valid_i      (stage_valid[DivSteps]),
    .item_i       (stage_item[DivSteps]),
    .valid_o      (out_valid),
    .hue_o        (hue),
    .saturation_o (saturation),
    .brightness_o (brightness)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = {1'b0, brightness, saturation, hue};

endmodule

@@ src/r2h_checker.sv @@
// Port-level checker for the RGB to HSV converter and its bind statement.
`include "rgb_to_hsv_converter_core_defines.svh"

module r2h_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic [r2h_pkg::InDataW-1:0]  s_axis_tdata_i,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [r2h_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import r2h_pkg::*;

  // A stalled result beat keeps its data.
  `R2H_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")

  // The input side is ready exactly when the output register can move.
  `R2H_ASSERT_NOW(a_ready_link, 1'b1, s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i), "input ready does not follow output state")

  // Hue stays below 360 degrees and the pad bit stays clear.
  `R2H_ASSERT_NOW(a_hue_range, m_axis_tvalid_o, m_axis_tdata_o[14:0] < HueFull && !m_axis_tdata_o[31], "hue out of range")

  // A black pixel gives zero saturation and the grey hue.
  `R2H_ASSERT_NOW(a_black, m_axis_tvalid_o && m_axis_tdata_o[30:23] == '0, m_axis_tdata_o[22:15] == '0 && m_axis_tdata_o[14:0] == HueGreyVal, "black pixel result wrong")

endmodule

bind rgb_to_hsv_converter_core r2h_checker u_r2h_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
